// ----- src/qenc_pkg.sv -----
// ----------------------------------------------------------------------------
// qenc_pkg
// Shared types and constants for the quadrature encoder tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package qenc_pkg;

  localparam int CNT_W            = 32;
  localparam int SCALE_W          = 10;
  localparam int CH_W             = 2;
  localparam int EMIT_MAX         = 4;
  localparam int QDEPTH           = 4;
  localparam int QAW              = 2;
  localparam logic [SCALE_W-1:0] RATE_SCALE_RESET = 10'd50;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // classified command between front and back
  typedef struct packed {
    logic            tick;
    logic            up;
    logic [CH_W-1:0] channel;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/qenc_front.sv -----
// ----------------------------------------------------------------------------
// qenc_front
// Accepts input items, drops edges on absent channels and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module qenc_front import qenc_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            opcode,
  input  wire logic [CH_W-1:0] channel,
  input  wire logic            phase_b,
  output logic                 q_valid,
  output cmd_t                 q_item,
  input  wire logic            q_pop
);

  cmd_t           queue [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;
  logic           accept;
  logic           push;
  logic           pop;
  cmd_t           cmd;

  assign in_stall = (fill == (QAW+1)'(QDEPTH));
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_item   = queue[rd_ptr];
  assign pop      = q_pop && q_valid;

  always_comb begin
    cmd.tick    = (opcode == OP_TICK);
    cmd.up      = phase_b;
    cmd.channel = channel;
    // drop edges on channels that are not built
    push = accept && (cmd.tick || (32'(channel) < CHANNELS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd;
    end
  end

endmodule

`default_nettype wire

// ----- src/qenc_back.sv -----
// ----------------------------------------------------------------------------
// qenc_back
// Applies edges to the channel counts and walks the channels on a tick,
// computing speed and acceleration through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module qenc_back import qenc_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [SCALE_W-1:0] rate_scale,
  input  wire logic               q_valid,
  input  wire cmd_t               q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [CNT_W-1:0]        position,
  output logic [CNT_W-1:0]        speed,
  output logic [CNT_W-1:0]        accel,
  output logic                    rotation,
  output logic                    last
);

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EMIT = (CHANNELS < EMIT_MAX) ? CHANNELS : EMIT_MAX;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SPD  = 3'b010,
    S_ACC  = 3'b100
  } back_state_t;

  back_state_t             state;
  logic [CW-1:0]           walk;
  logic [CNT_W-1:0]        spd;
  logic [CNT_W-1:0]        count_now    [CHANNELS];
  logic [CNT_W-1:0]        count_before [CHANNELS];
  logic [CNT_W-1:0]        speed_before [CHANNELS];
  logic                    dir_flag     [CHANNELS];

  logic [CW-1:0]           edge_idx;
  logic [CW-1:0]           rd_idx;
  logic [CNT_W-1:0]        cn_rd;
  logic [CNT_W-1:0]        mul_in;
  logic [CNT_W+SCALE_W-1:0] prod;
  logic [CNT_W-1:0]        mul_lo;
  logic                    emit;
  logic                    out_free;
  logic                    walk_end;
  logic                    acc_go;

  always_comb begin
    edge_idx = CW'(q_item.channel);
    rd_idx   = (state == S_IDLE) ? edge_idx : walk;
    cn_rd    = count_now[rd_idx];
    // speed pass scales the count delta, accel pass the speed delta
    mul_in   = (state == S_SPD) ? (cn_rd - count_before[rd_idx])
                                : (spd - speed_before[rd_idx]);
    prod     = {{SCALE_W{1'b0}}, mul_in} * {{CNT_W{1'b0}}, rate_scale};
    mul_lo   = prod[CNT_W-1:0];
    emit     = (32'(walk) < EMIT);
    out_free = !out_valid || !out_stall;
    walk_end = (walk == CW'(CHANNELS - 1));
    acc_go   = (state == S_ACC) && (!emit || out_free);
    q_pop    = (state == S_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      walk      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        count_now[i]    <= '0;
        count_before[i] <= '0;
        speed_before[i] <= '0;
        dir_flag[i]     <= 1'b0;
      end
    end else begin
      // load a new result, else drop the old one once it is taken
      if (acc_go && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.tick) begin
              walk  <= '0;
              state <= S_SPD;
            end else begin
              count_now[edge_idx] <= q_item.up ? cn_rd + 1'b1 : cn_rd - 1'b1;
              dir_flag[edge_idx]  <= !q_item.up;
            end
          end
        end
        S_SPD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          // hold until the output register can take the result
          if (acc_go) begin
            count_before[walk] <= cn_rd;
            speed_before[walk] <= spd;
            if (walk_end) begin
              state <= S_IDLE;
            end else begin
              walk  <= walk + 1'b1;
              state <= S_SPD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SPD) begin
      spd <= mul_lo;
    end
    if (acc_go && emit) begin
      out_channel <= CH_W'(walk);
      position    <= cn_rd;
      speed       <= spd;
      accel       <= mul_lo;
      rotation    <= dir_flag[walk];
      last        <= (walk == CW'(EMIT - 1));
    end
  end

endmodule

`default_nettype wire

// ----- src/quad_encoder_count_speed_accel.sv -----
// ----------------------------------------------------------------------------
// quad_encoder_count_speed_accel
// Multi-channel quadrature encoder tracker: position, speed and acceleration.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_we               cfg_wdata (rate_scale)
//   in        in         in_valid/in_stall    opcode, channel, phase_b
//   out       out        out_valid/out_stall  out_channel, position, speed,
//                                             accel, rotation, last
//
// An edge item is applied to its count as it leaves the queue; a tick leaves
// the queue, then each channel takes a speed pass and an accel pass (both
// through one 32x10 multiplier), and the accel pass holds on an output stall.
// A four-entry queue lets edges be accepted while a tick is being walked.
// Synchronous reset clears all counts, history and direction flags and sets
// rate_scale to 50.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_encoder_count_speed_accel import qenc_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [SCALE_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [CH_W-1:0]    channel,
  input  wire logic               phase_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [CNT_W-1:0]        position,
  output logic signed [CNT_W-1:0] speed,
  output logic signed [CNT_W-1:0] accel,
  output logic                    rotation,
  output logic                    last
);

  logic [SCALE_W-1:0] rate_scale;
  logic               q_valid;
  cmd_t               q_item;
  logic               q_pop;
  logic [CNT_W-1:0]   speed_u;
  logic [CNT_W-1:0]   accel_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale <= RATE_SCALE_RESET;
    end else if (cfg_we) begin
      rate_scale <= cfg_wdata;
    end
  end

  qenc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .channel  (channel),
    .phase_b  (phase_b),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  qenc_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .rate_scale  (rate_scale),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .position    (position),
    .speed       (speed_u),
    .accel       (accel_u),
    .rotation    (rotation),
    .last        (last)
  );

  assign speed = $signed(speed_u);
  assign accel = $signed(accel_u);

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrature encoder tracker. Edge and tick items
// go through a randomly idling driver; every accepted item updates an
// in-bench copy of the per-channel counts, speeds and directions, and each
// tick queues four expected channel reports. The monitor pops them in order
// and compares every field. The rate scale is rewritten between phases,
// covering zero, one, the reset value, the maximum and a random value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import qenc_pkg::*; ();

  localparam int NCH       = 4;
  localparam int RUN_LIMIT = 200000;
  localparam int SETTLE    = 40;

  typedef struct {
    logic            op;
    logic [CH_W-1:0] ch;
    logic            pb;
  } enc_item_t;

  typedef struct {
    logic [CH_W-1:0]         ch;
    logic [CNT_W-1:0]        pos;
    logic signed [CNT_W-1:0] spd;
    logic signed [CNT_W-1:0] acc;
    logic                    rot;
    logic                    lst;
  } chan_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [SCALE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_EDGE;
  logic [CH_W-1:0] channel = '0;
  logic phase_b = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] out_channel;
  logic [CNT_W-1:0] position;
  logic signed [CNT_W-1:0] speed;
  logic signed [CNT_W-1:0] accel;
  logic rotation;
  logic last;

  // tracker copy kept by the bench
  logic [CNT_W-1:0]   pos_now [NCH];
  logic [CNT_W-1:0]   pos_prev [NCH];
  logic [CNT_W-1:0]   spd_prev [NCH];
  logic               ccw [NCH];
  logic [SCALE_W-1:0] scale_now = RATE_SCALE_RESET;

  enc_item_t    edge_tick_q[$];
  chan_report_t report_q[$];

  logic in_sent = 1'b0;
  logic calm = 1'b0;
  int   mismatches = 0;
  int   items_taken = 0;
  int   reports_seen = 0;
  int   scales_used = 1;
  int   cycles = 0;

  quad_encoder_count_speed_accel #(.CHANNELS(NCH)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .channel(channel), .phase_b(phase_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_channel(out_channel), .position(position), .speed(speed),
    .accel(accel), .rotation(rotation), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NCH; i++) begin
      pos_now[i] = '0;
      pos_prev[i] = '0;
      spd_prev[i] = '0;
      ccw[i] = 1'b0;
    end
  end

  // Apply one accepted item to the tracker copy; a tick queues the reports.
  function void advance_encoders(enc_item_t it);
    chan_report_t r;
    logic [CNT_W-1:0] spd;
    logic [CNT_W-1:0] acc;
    if (it.op == OP_EDGE) begin
      if (it.pb) begin
        ccw[it.ch] = 1'b0;
        pos_now[it.ch] = pos_now[it.ch] + 1;
      end else begin
        ccw[it.ch] = 1'b1;
        pos_now[it.ch] = pos_now[it.ch] - 1;
      end
    end else begin
      for (int i = 0; i < NCH; i++) begin
        spd = (pos_now[i] - pos_prev[i]) * {{(CNT_W-SCALE_W){1'b0}}, scale_now};
        acc = (spd - spd_prev[i]) * {{(CNT_W-SCALE_W){1'b0}}, scale_now};
        r.ch = CH_W'(i);
        r.pos = pos_now[i];
        r.spd = spd;
        r.acc = acc;
        r.rot = ccw[i];
        r.lst = (i == NCH - 1);
        report_q.push_back(r);
        pos_prev[i] = pos_now[i];
        spd_prev[i] = spd;
      end
    end
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // input side: record accepted items
  always @(posedge clk) begin
    in_sent <= in_valid && in_stall === 1'b0;
    if (in_valid && in_stall === 1'b0) begin
      advance_encoders('{op: opcode, ch: channel, pb: phase_b});
      items_taken++;
    end
  end

  // driver: change inputs on the falling edge
  always @(negedge clk) begin : drive
    enc_item_t it;
    if (!in_valid || in_sent) begin
      if (edge_tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
        it = edge_tick_q.pop_front();
        in_valid <= 1'b1;
        opcode <= it.op;
        channel <= it.ch;
        phase_b <= it.pb;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && $urandom_range(0, 99) < 31;
  end

  // monitor: compare each accepted report with the oldest expectation
  always @(posedge clk) begin : watch
    chan_report_t r;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report: expected none, got channel %0d position %h",
                 $time, out_channel, position);
        mismatches++;
      end else begin
        r = report_q.pop_front();
        check_field("out_channel", CNT_W'(r.ch), CNT_W'(out_channel));
        check_field("position", r.pos, position);
        check_field("speed", r.spd, speed);
        check_field("accel", r.acc, accel);
        check_field("rotation", CNT_W'(r.rot), CNT_W'(rotation));
        check_field("last", CNT_W'(r.lst), CNT_W'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, report_q.size());
      $display("FAIL quad_encoder_count_speed_accel");
      $finish;
    end
  end

  task automatic queue_item(logic op, logic [CH_W-1:0] ch, logic pb);
    edge_tick_q.push_back('{op: op, ch: ch, pb: pb});
  endtask

  // Mostly edges leaning one way so speeds and accelerations build up.
  task automatic queue_random(int n);
    logic lean;
    lean = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        queue_item(OP_TICK, CH_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        lean = 1'($urandom_range(0, 1));
      end else begin
        queue_item(OP_EDGE, CH_W'($urandom_range(0, 3)),
                   ($urandom_range(0, 3) != 0) ? lean : 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Hold until everything sent has been answered, then let the pipe drain.
  task automatic settle();
    do @(negedge clk);
    while (edge_tick_q.size() != 0 || in_valid || report_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    scale_now = v;
    scales_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed: fresh state, channels 0 to 2 both ways, channel 3 up only, wrap below zero
    queue_item(OP_TICK, 2'd0, 1'b0);
    queue_item(OP_EDGE, 2'd0, 1'b1);
    queue_item(OP_EDGE, 2'd1, 1'b1);
    queue_item(OP_EDGE, 2'd2, 1'b0);
    queue_item(OP_EDGE, 2'd3, 1'b1);
    queue_item(OP_EDGE, 2'd3, 1'b1);
    queue_item(OP_TICK, 2'd3, 1'b1);
    queue_item(OP_EDGE, 2'd0, 1'b0);
    queue_item(OP_EDGE, 2'd0, 1'b0);
    queue_item(OP_EDGE, 2'd1, 1'b0);
    queue_item(OP_TICK, 2'd2, 1'b0);
    queue_item(OP_TICK, 2'd1, 1'b1);
    queue_item(OP_EDGE, 2'd2, 1'b1);
    queue_item(OP_EDGE, 2'd2, 1'b1);
    queue_item(OP_EDGE, 2'd2, 1'b1);
    queue_item(OP_TICK, 2'd0, 1'b1);
    queue_random(20);
    settle();

    write_scale(10'd1023);
    queue_random(30);
    queue_item(OP_TICK, 2'd0, 1'b0);
    settle();

    write_scale(10'd0);
    queue_random(15);
    queue_item(OP_TICK, 2'd3, 1'b0);
    settle();

    write_scale(10'd1);
    queue_random(15);
    queue_item(OP_TICK, 2'd1, 1'b1);
    settle();

    // no idling on either side for this stretch
    write_scale(SCALE_W'($urandom_range(2, 1022)));
    calm = 1'b1;
    queue_random(20);
    queue_item(OP_TICK, 2'd2, 1'b1);
    settle();
    calm = 1'b0;

    $display("%0d edge/tick items driven, %0d channel reports checked, %0d scale settings",
             items_taken, reports_seen, scales_used);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("PASS quad_encoder_count_speed_accel");
    end else begin
      $display("FAIL quad_encoder_count_speed_accel");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/qenc_pkg.sv
src/qenc_front.sv
src/qenc_back.sv
src/quad_encoder_count_speed_accel.sv
tb/sv/tb_top.sv
